// ===== rtl/core/segment_map_allocator_assert.svh =====
// Assertion macros used by the allocator RTL.
`ifndef SEGMENT_MAP_ALLOCATOR_ASSERT_SVH
`define SEGMENT_MAP_ALLOCATOR_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define SMAP_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that post holds in the cycle after pre.
`define SMAP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/smap_pkg.sv =====
// Package: types, sizes and codes of the segment map allocator.
`timescale 1ns / 1ps
package smap_pkg;

    localparam int MAP_ENTRIES = 64;
    localparam int IDX_BITS    = $clog2(MAP_ENTRIES);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int ADDR_BITS   = 16;
    localparam int SIZE_BITS   = ADDR_BITS + 1;
    localparam int OWNER_BITS  = 8;
    localparam logic [SIZE_BITS-1:0] MEM_CAP = SIZE_BITS'(1) << ADDR_BITS;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  seg_start;
        logic [ADDR_BITS-1:0]  seg_end;
        logic [SIZE_BITS-1:0]  seg_size;
        logic [OWNER_BITS-1:0] seg_owner;
    } seg_t;

    localparam seg_t RESET_SEG = '{seg_start: '0, seg_end: '1,
                                   seg_size: MEM_CAP, seg_owner: '0};

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0, CMD_RELEASE = 2'd1, CMD_INIT = 2'd2, CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        FIT_BEST = 2'd0, FIT_FIRST = 2'd1, FIT_WORST = 2'd2, FIT_NEXT = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NO_FIT = 3'd1, ST_FULL = 3'd2, ST_NOT_FOUND = 3'd3,
        ST_BAD_SIZE = 3'd4
    } status_t;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_WORDS  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_HINT_RD, S_HINT_CHK, S_SCAN_RD, S_SCAN_CHK, S_TAKE,
        S_SHIFT_RD, S_SHIFT_WR, S_SPLIT, S_SPLIT2, S_REL_RD, S_REL_CHK,
        S_PREV_RD, S_PREV_CHK, S_NEXT_RD, S_NEXT_CHK, S_MERGE,
        S_REM_RD, S_REM_WR, S_FIN
    } state_t;

endpackage

// ===== rtl/core/smap_table.sv =====
// Segment table memory with registered read and reset image of entry zero.
`timescale 1ns / 1ps
module smap_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [smap_pkg::IDX_BITS-1:0] rd_addr,
    output smap_pkg::seg_t                rd_data,
    input  logic                          wr_en,
    input  logic [smap_pkg::IDX_BITS-1:0] wr_addr,
    input  smap_pkg::seg_t                wr_data
);
    import smap_pkg::*;

    seg_t mem_reg [MAP_ENTRIES];
    seg_t rd_q_reg;
    logic pend_reg;
    logic rd_zero_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem_reg[rd_addr];
    end

    // Track entry zero until it is first written after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b1;
            rd_zero_reg <= 1'b0;
        end
        else
        begin
            rd_zero_reg <= pend_reg && (rd_addr == '0);
            if (wr_en && (wr_addr == '0))
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    assign rd_data = rd_zero_reg ? RESET_SEG : rd_q_reg;

endmodule

// ===== rtl/core/segment_map_allocator.sv =====
// Top level: segment map allocator sequencer around the segment table memory.
// Allocate scans the table (after a hint search for next fit), then, unless the fit
//   is exact, shifts later entries up and splits off the free remainder.
// Release searches, merges free neighbours and compacts; init, no-op and zero-size
//   requests go straight to the finish state. One word in work at a time.
// Reset: table holds one free segment of 65536 words, policy best fit.
`timescale 1ns / 1ps
module segment_map_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic [16:0]                      alloc_words,
    input  logic [7:0]                       owner_id,
    input  logic [15:0]                      hint_start,
    input  logic [15:0]                      release_start,
    input  logic [15:0]                      release_end,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      block_start,
    output logic [15:0]                      block_end,
    output logic [16:0]                      block_size,
    output logic [7:0]                       block_owner,
    output logic [2:0]                       status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [16:0]                      cfg_data
);
    import smap_pkg::*;
    `include "segment_map_allocator_assert.svh"

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] i_reg, i_next, k_reg, k_next, first_reg, first_next;
    logic [CNT_BITS-1:0] j_reg, j_next;
    logic [1:0] shd_reg, shd_next;
    logic found_reg, found_next;
    logic [IDX_BITS-1:0] cidx_reg, cidx_next;
    seg_t cand_reg, cand_next, prev_reg, prev_next, nxt_reg, nxt_next;
    logic prev_free_reg, prev_free_next, next_free_reg, next_free_next;
    logic [1:0] cmd_reg;
    logic [16:0] req_reg;
    logic [7:0] own_reg;
    logic [15:0] hint_reg, rs_reg, re_reg;
    seg_t res_reg, res_next;
    status_t rst_reg, rst_next;
    logic [1:0] pol_reg;
    logic [16:0] mw_reg;
    logic out_valid_reg;
    seg_t out_seg_reg;
    status_t out_st_reg;

    logic [IDX_BITS-1:0] rd_addr, wr_addr;
    logic wr_en;
    seg_t rd_data, wr_data;
    logic load_out;

    logic [CNT_BITS:0] wrap_sum;
    logic [CNT_BITS-1:0] scan_idx;
    logic fit, better, found_upd;
    logic [16:0] words;

    smap_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Clamp the configured memory size for init
    always_comb
    begin
        if (mw_reg == '0)
            words = 17'd1;
        else if (mw_reg > MEM_CAP)
            words = MEM_CAP;
        else
            words = mw_reg;
    end

    assign wrap_sum = {1'b0, first_reg} + {1'b0, k_reg};
    assign scan_idx = (wrap_sum >= {1'b0, cnt_reg}) ?
                      CNT_BITS'(wrap_sum - {1'b0, cnt_reg}) : CNT_BITS'(wrap_sum);
    assign fit    = (rd_data.seg_owner == '0) && (rd_data.seg_size >= req_reg);
    assign better = (pol_reg == FIT_BEST) ? (rd_data.seg_size < cand_reg.seg_size)
                                          : (rd_data.seg_size > cand_reg.seg_size);
    assign found_upd = found_reg || fit;

    // Sequence: next state, memory accesses and working registers
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        j_next         = j_reg;
        shd_next       = shd_reg;
        found_next     = found_reg;
        cidx_next      = cidx_reg;
        cand_next      = cand_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        prev_free_next = prev_free_reg;
        next_free_next = next_free_reg;
        res_next       = res_reg;
        rst_next       = rst_reg;
        rd_addr        = i_reg[IDX_BITS-1:0];
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data;
        load_out       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = '0;
                    rst_next   = ST_OK;
                    i_next     = '0;
                    k_next     = '0;
                    first_next = '0;
                    found_next = 1'b0;
                    unique case (cmd_t'(cmd))
                        CMD_ALLOC:
                        begin
                            if (alloc_words == '0)
                            begin
                                rst_next   = ST_BAD_SIZE;
                                state_next = S_FIN;
                            end
                            else if (policy_t'(pol_reg) == FIT_NEXT)
                                state_next = S_HINT_RD;
                            else
                                state_next = S_SCAN_RD;
                        end
                        CMD_RELEASE: state_next = S_REL_RD;
                        CMD_INIT:    state_next = S_FIN;
                        CMD_NOP:     state_next = S_FIN;
                    endcase
                end
            end
            S_HINT_RD:
            begin
                rd_addr    = i_reg[IDX_BITS-1:0];
                state_next = S_HINT_CHK;
            end
            S_HINT_CHK:
            begin
                if (rd_data.seg_start == hint_reg)
                begin
                    first_next = (i_reg + 1'b1 >= cnt_reg) ? '0 : i_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (i_reg + 1'b1 >= cnt_reg)
                    state_next = S_SCAN_RD;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_HINT_RD;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr    = scan_idx[IDX_BITS-1:0];
                i_next     = scan_idx;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                k_next     = k_reg + 1'b1;
                state_next = S_SCAN_RD;
                if (pol_reg == FIT_BEST || pol_reg == FIT_WORST)
                begin
                    if (fit && rd_data.seg_size == req_reg)
                    begin
                        cand_next  = rd_data;
                        cidx_next  = i_reg[IDX_BITS-1:0];
                        state_next = S_TAKE;
                    end
                    else
                    begin
                        if (fit && (!found_reg || better))
                        begin
                            cand_next  = rd_data;
                            cidx_next  = i_reg[IDX_BITS-1:0];
                            found_next = 1'b1;
                        end
                        if (k_reg + 1'b1 >= cnt_reg)
                        begin
                            if (found_upd)
                                state_next = S_TAKE;
                            else
                            begin
                                rst_next   = ST_NO_FIT;
                                state_next = S_FIN;
                            end
                        end
                    end
                end
                else if (fit)
                begin
                    cand_next  = rd_data;
                    cidx_next  = i_reg[IDX_BITS-1:0];
                    state_next = S_TAKE;
                end
                else if (k_reg + 1'b1 >= cnt_reg)
                begin
                    rst_next   = ST_NO_FIT;
                    state_next = S_FIN;
                end
            end
            S_TAKE:
            begin
                if (cand_reg.seg_size == req_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = cidx_reg;
                    wr_data    = cand_reg;
                    wr_data.seg_owner = own_reg;
                    res_next   = wr_data;
                    state_next = S_FIN;
                end
                else if (cnt_reg >= CNT_BITS'(MAP_ENTRIES))
                begin
                    rst_next   = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    j_next     = cnt_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (j_reg > {1'b0, cidx_reg} + 1'b1)
                begin
                    rd_addr    = IDX_BITS'(j_reg - 1'b1);
                    state_next = S_SHIFT_WR;
                end
                else
                    state_next = S_SPLIT;
            end
            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IDX_BITS-1:0];
                wr_data    = rd_data;
                j_next     = j_reg - 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_SPLIT:
            begin
                // Insert the free remainder after the chosen segment
                wr_en             = 1'b1;
                wr_addr           = cidx_reg + 1'b1;
                wr_data.seg_start = cand_reg.seg_start + req_reg[15:0];
                wr_data.seg_end   = cand_reg.seg_end;
                wr_data.seg_size  = cand_reg.seg_size - req_reg;
                wr_data.seg_owner = '0;
                state_next        = S_SPLIT2;
            end
            S_SPLIT2:
            begin
                wr_en             = 1'b1;
                wr_addr           = cidx_reg;
                wr_data.seg_start = cand_reg.seg_start;
                wr_data.seg_end   = cand_reg.seg_start + req_reg[15:0] - 16'd1;
                wr_data.seg_size  = req_reg;
                wr_data.seg_owner = own_reg;
                res_next          = wr_data;
                cnt_next          = cnt_reg + 1'b1;
                state_next        = S_FIN;
            end
            S_REL_RD:
            begin
                rd_addr    = i_reg[IDX_BITS-1:0];
                state_next = S_REL_CHK;
            end
            S_REL_CHK:
            begin
                if (rd_data.seg_start == rs_reg && rd_data.seg_end == re_reg &&
                    rd_data.seg_owner == own_reg)
                begin
                    cand_next      = rd_data;
                    cidx_next      = i_reg[IDX_BITS-1:0];
                    prev_free_next = 1'b0;
                    next_free_next = 1'b0;
                    state_next     = (i_reg == '0) ? S_NEXT_RD : S_PREV_RD;
                end
                else if (i_reg + 1'b1 >= cnt_reg)
                begin
                    rst_next   = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_REL_RD;
                end
            end
            S_PREV_RD:
            begin
                rd_addr    = cidx_reg - 1'b1;
                state_next = S_PREV_CHK;
            end
            S_PREV_CHK:
            begin
                prev_next      = rd_data;
                prev_free_next = (rd_data.seg_owner == '0);
                state_next     = S_NEXT_RD;
            end
            S_NEXT_RD:
            begin
                rd_addr    = cidx_reg + 1'b1;
                state_next = ({1'b0, cidx_reg} + 1'b1 < cnt_reg) ? S_NEXT_CHK : S_MERGE;
            end
            S_NEXT_CHK:
            begin
                nxt_next       = rd_data;
                next_free_next = (rd_data.seg_owner == '0);
                state_next     = S_MERGE;
            end
            S_MERGE:
            begin
                // Free the segment and fold in free neighbours
                wr_en             = 1'b1;
                wr_data.seg_owner = '0;
                state_next        = S_REM_RD;
                if (prev_free_reg)
                begin
                    wr_addr           = cidx_reg - 1'b1;
                    wr_data.seg_start = prev_reg.seg_start;
                    wr_data.seg_end   = next_free_reg ? nxt_reg.seg_end : cand_reg.seg_end;
                    wr_data.seg_size  = prev_reg.seg_size + cand_reg.seg_size +
                                        (next_free_reg ? nxt_reg.seg_size : 17'd0);
                    j_next            = {1'b0, cidx_reg};
                    shd_next          = next_free_reg ? 2'd2 : 2'd1;
                end
                else
                begin
                    wr_addr           = cidx_reg;
                    wr_data.seg_start = cand_reg.seg_start;
                    wr_data.seg_end   = next_free_reg ? nxt_reg.seg_end : cand_reg.seg_end;
                    wr_data.seg_size  = cand_reg.seg_size +
                                        (next_free_reg ? nxt_reg.seg_size : 17'd0);
                    j_next            = {1'b0, cidx_reg} + 1'b1;
                    shd_next          = next_free_reg ? 2'd1 : 2'd0;
                    if (!next_free_reg)
                        state_next = S_FIN;
                end
            end
            S_REM_RD:
            begin
                if (j_reg + CNT_BITS'(shd_reg) < cnt_reg)
                begin
                    rd_addr    = IDX_BITS'(j_reg + CNT_BITS'(shd_reg));
                    state_next = S_REM_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_BITS'(shd_reg);
                    state_next = S_FIN;
                end
            end
            S_REM_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IDX_BITS-1:0];
                wr_data    = rd_data;
                j_next     = j_reg + 1'b1;
                state_next = S_REM_RD;
            end
            S_FIN:
            begin
                if (cmd_t'(cmd_reg) == CMD_INIT)
                begin
                    wr_en             = 1'b1;
                    wr_addr           = '0;
                    wr_data.seg_start = '0;
                    wr_data.seg_end   = 16'(words - 17'd1);
                    wr_data.seg_size  = words;
                    wr_data.seg_owner = '0;
                    cnt_next          = CNT_BITS'(1);
                end
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
                if (cmd_t'(cmd_reg) == CMD_INIT && !load_out)
                    wr_en = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CNT_BITS'(1);
            pol_reg       <= FIT_BEST;
            mw_reg        <= MEM_CAP;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_POLICY)
                    pol_reg <= cfg_data[1:0];
                else
                    mw_reg <= cfg_data;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Advance working and payload registers
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        k_reg         <= k_next;
        first_reg     <= first_next;
        j_reg         <= j_next;
        shd_reg       <= shd_next;
        cidx_reg      <= cidx_next;
        cand_reg      <= cand_next;
        prev_reg      <= prev_next;
        nxt_reg       <= nxt_next;
        prev_free_reg <= prev_free_next;
        next_free_reg <= next_free_next;
        res_reg       <= res_next;
        rst_reg       <= rst_next;
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            req_reg  <= alloc_words;
            own_reg  <= owner_id;
            hint_reg <= hint_start;
            rs_reg   <= release_start;
            re_reg   <= release_end;
        end
        if (load_out)
        begin
            out_seg_reg <= res_reg;
            out_st_reg  <= rst_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_start = out_seg_reg.seg_start;
    assign block_end   = out_seg_reg.seg_end;
    assign block_size  = out_seg_reg.seg_size;
    assign block_owner = out_seg_reg.seg_owner;
    assign status      = out_st_reg;

    `SMAP_ASSERT(a_cnt_range, (cnt_reg != '0) && (cnt_reg <= CNT_BITS'(MAP_ENTRIES)))
    `SMAP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_reg != S_IDLE)
    `SMAP_ASSERT_NEXT(a_load_valid, load_out, out_valid_reg)
    `SMAP_ASSERT(a_fin_status, !(load_out && rst_reg == ST_OK && cmd_reg == CMD_RELEASE &&
                                 res_reg.seg_size != '0))

endmodule

// ===== bench/smap_checker.sv =====
// Checker: predicts segment map allocator results and compares them.
`timescale 1ns / 1ps
module smap_checker
    import smap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [16:0] alloc_words,
    input  logic [7:0]  owner_id,
    input  logic [15:0] hint_start,
    input  logic [15:0] release_start,
    input  logic [15:0] release_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] block_start,
    input  logic [15:0] block_end,
    input  logic [16:0] block_size,
    input  logic [7:0]  block_owner,
    input  logic [2:0]  status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [15:0] b_start;
        logic [15:0] b_end;
        logic [16:0] b_size;
        logic [7:0]  b_owner;
        logic [2:0]  b_status;
    } grant_t;

    seg_t        seg_map [MAP_ENTRIES];
    int          seg_count;
    policy_t     policy;
    logic [16:0] words_cfg;
    grant_t      grant_queue [$];

    // Rebuild the table as one free segment
    function automatic void map_init();
        logic [16:0] w;
        w = words_cfg;
        if (w == 0) w = 1;
        if (w > MEM_CAP) w = MEM_CAP;
        seg_map[0] = '{seg_start: '0, seg_end: 16'(w - 1), seg_size: w, seg_owner: '0};
        seg_count = 1;
    endfunction

    function automatic grant_t make_grant(logic [15:0] s, logic [15:0] e, logic [16:0] sz,
                                          logic [7:0] o, status_t st);
        grant_t g;
        g = '{b_start: s, b_end: e, b_size: sz, b_owner: o, b_status: st};
        return g;
    endfunction

    // Take segment idx for req words, splitting when it is larger and the table has room
    function automatic grant_t carve(int idx, logic [16:0] req, logic [7:0] own);
        if (seg_map[idx].seg_size == req) begin
            seg_map[idx].seg_owner = own;
            return make_grant(seg_map[idx].seg_start, seg_map[idx].seg_end, req, own, ST_OK);
        end
        if (seg_count >= MAP_ENTRIES) return make_grant(0, 0, 0, 0, ST_FULL);
        for (int j = seg_count; j > idx + 1; j--) seg_map[j] = seg_map[j-1];
        seg_map[idx+1].seg_start = seg_map[idx].seg_start + 16'(req);
        seg_map[idx+1].seg_end   = seg_map[idx].seg_end;
        seg_map[idx+1].seg_size  = seg_map[idx].seg_size - req;
        seg_map[idx+1].seg_owner = '0;
        seg_map[idx].seg_end     = seg_map[idx].seg_start + 16'(req - 1);
        seg_map[idx].seg_size    = req;
        seg_map[idx].seg_owner   = own;
        seg_count++;
        return make_grant(seg_map[idx].seg_start, seg_map[idx].seg_end, req, own, ST_OK);
    endfunction

    function automatic grant_t allocate(logic [16:0] req, logic [7:0] own, logic [15:0] hint);
        int  pick;
        int  i;
        bit  found;
        pick = 0;
        found = 0;
        if (req == 0) return make_grant(0, 0, 0, 0, ST_BAD_SIZE);
        if (policy == FIT_BEST || policy == FIT_WORST) begin
            for (i = 0; i < seg_count; i++) begin
                if (seg_map[i].seg_owner != 0 || seg_map[i].seg_size < req) continue;
                if (seg_map[i].seg_size == req) return carve(i, req, own);
                if (!found || (policy == FIT_BEST && seg_map[i].seg_size < seg_map[pick].seg_size)
                    || (policy == FIT_WORST && seg_map[i].seg_size > seg_map[pick].seg_size))
                begin
                    pick = i;
                    found = 1;
                end
            end
            if (found) return carve(pick, req, own);
            return make_grant(0, 0, 0, 0, ST_NO_FIT);
        end
        if (policy == FIT_NEXT) begin
            for (i = 0; i < seg_count; i++)
                if (seg_map[i].seg_start == hint) begin
                    pick = i + 1;
                    break;
                end
            if (pick >= seg_count) pick = 0;
        end
        for (int k = 0; k < seg_count; k++) begin
            i = pick + k;
            if (i >= seg_count) i -= seg_count;
            if (seg_map[i].seg_owner == 0 && seg_map[i].seg_size >= req)
                return carve(i, req, own);
        end
        return make_grant(0, 0, 0, 0, ST_NO_FIT);
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < seg_count; i++) seg_map[i] = seg_map[i+1];
        seg_count--;
    endfunction

    function automatic grant_t release_seg(logic [15:0] s, logic [15:0] e, logic [7:0] own);
        int idx;
        idx = -1;
        for (int i = 0; i < seg_count; i++)
            if (seg_map[i].seg_start == s && seg_map[i].seg_end == e
                && seg_map[i].seg_owner == own) begin
                idx = i;
                break;
            end
        if (idx < 0) return make_grant(0, 0, 0, 0, ST_NOT_FOUND);
        seg_map[idx].seg_owner = '0;
        // Merge with free neighbours
        if (idx > 0 && seg_map[idx-1].seg_owner == 0) begin
            seg_map[idx-1].seg_end = seg_map[idx].seg_end;
            seg_map[idx-1].seg_size += seg_map[idx].seg_size;
            drop_entry(idx);
            idx--;
        end
        if (idx + 1 < seg_count && seg_map[idx+1].seg_owner == 0) begin
            seg_map[idx].seg_end = seg_map[idx+1].seg_end;
            seg_map[idx].seg_size += seg_map[idx+1].seg_size;
            drop_entry(idx + 1);
        end
        return make_grant(0, 0, 0, 0, ST_OK);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        grant_t got;
        if (!rst_n) begin
            policy = FIT_BEST;
            words_cfg = 17'd65536;
            map_init();
            grant_queue.delete();
            fail_count = 0;
        end else begin
            // Compare a delivered word with the oldest expectation
            if (out_valid && out_ready) begin
                got = '{b_start: block_start, b_end: block_end, b_size: block_size,
                        b_owner: block_owner, b_status: status};
                if (grant_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", got);
                end else begin
                    g = grant_queue.pop_front();
                    if (g !== got) begin
                        fail_count++;
                        if (fail_count <= 10) $display("mismatch exp %p got %p", g, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_POLICY) policy = policy_t'(cfg_data[1:0]);
                else words_cfg = cfg_data;
            end
            if (in_valid && in_ready) begin
                case (cmd_t'(cmd))
                    CMD_ALLOC:   g = allocate(alloc_words, owner_id, hint_start);
                    CMD_RELEASE: g = release_seg(release_start, release_end, owner_id);
                    CMD_INIT:
                    begin
                        map_init();
                        g = make_grant(0, 0, 0, 0, ST_OK);
                    end
                    default:     g = make_grant(0, 0, 0, 0, ST_OK);
                endcase
                grant_queue.push_back(g);
            end
        end
        pending_count = grant_queue.size();
    end

endmodule

// ===== bench/tb_segment_map_allocator.sv =====
// Testbench top: stimulus for the segment map allocator and the verdict.
`timescale 1ns / 1ps
module tb_segment_map_allocator;
    import smap_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [1:0]  cmd;
    logic [16:0] alloc_words;
    logic [7:0]  owner_id;
    logic [15:0] hint_start, release_start, release_end;
    logic [15:0] block_start, block_end;
    logic [16:0] block_size;
    logic [7:0]  block_owner;
    logic [2:0]  status;
    logic        cfg_valid, cfg_ready, cfg_index;
    logic [16:0] cfg_data;
    int          fail_count, pending_count;
    int          idle_send, idle_recv;
    int          quiet_cycles;

    // Live allocations, kept so that releases mostly hit
    logic [15:0] held_start [$];
    logic [15:0] held_end [$];
    logic [7:0]  held_owner [$];
    logic [15:0] last_start;

    localparam int WATCHDOG = 20000;

    segment_map_allocator DUT (.*);

    smap_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver stalls at random
    always @(negedge clk) out_ready <= ($urandom_range(99) >= idle_recv);

    // Note each accepted allocation for later release, and fail the run when nothing moves
    always @(posedge clk)
    begin
        if (out_valid && out_ready && status == ST_OK && block_size != 0) begin
            held_start.push_back(block_start);
            held_end.push_back(block_end);
            held_owner.push_back(block_owner);
            last_start = block_start;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(cmd_t c, logic [16:0] sz, logic [7:0] o, logic [15:0] h,
                             logic [15:0] rs, logic [15:0] re);
        while ($urandom_range(99) < idle_send) @(negedge clk);
        cmd <= c;
        alloc_words <= sz;
        owner_id <= o;
        hint_start <= h;
        release_start <= rs;
        release_end <= re;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] val);
        drain();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word(int words);
        int pick, k;
        pick = $urandom_range(99);
        if (pick < 50) begin
            // Mostly small requests, a few large or odd ones
            send_word(CMD_ALLOC,
                      ($urandom_range(9) == 0) ? 17'($urandom_range(65536))
                                               : 17'($urandom_range(words / 8 + 2)),
                      8'($urandom_range(255)),
                      ($urandom_range(1) && held_start.size() != 0) ? last_start
                                                                    : 16'($urandom),
                      16'($urandom), 16'($urandom));
        end else if (pick < 88 && held_start.size() != 0) begin
            k = $urandom_range(held_start.size() - 1);
            send_word(CMD_RELEASE, 17'($urandom), held_owner[k], 16'($urandom),
                      held_start[k], held_end[k]);
            held_start.delete(k);
            held_end.delete(k);
            held_owner.delete(k);
        end else if (pick < 93) begin
            send_word(CMD_RELEASE, 17'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        end else if (pick < 97) begin
            send_word(CMD_NOP, 17'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        end else begin
            send_word(CMD_INIT, 17'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
            held_start.delete();
            held_end.delete();
            held_owner.delete();
        end
    endtask

    initial
    begin
        int words;
        quiet_cycles = 0;
        idle_send = 32;
        idle_recv = 54;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        cmd = CMD_NOP;
        alloc_words = '0;
        owner_id = '0;
        hint_start = '0;
        release_start = '0;
        release_end = '0;
        last_start = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every command and the special cases
        send_word(CMD_ALLOC, 17'd0, 8'd1, 16'd0, 16'd0, 16'd0);
        send_word(CMD_ALLOC, 17'd65536, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_RELEASE, 17'd0, 8'd255, 16'd0, 16'd0, 16'hFFFF);
        send_word(CMD_ALLOC, 17'd100, 8'd0, 16'd0, 16'd0, 16'd0);
        send_word(CMD_ALLOC, 17'd200, 8'd7, 16'd0, 16'd0, 16'd0);
        send_word(CMD_RELEASE, 17'd0, 8'd0, 16'd0, 16'd0, 16'd99);
        send_word(CMD_RELEASE, 17'd0, 8'd9, 16'd0, 16'd1, 16'd2);
        send_word(CMD_ALLOC, 17'd70000 & 17'h1FFFF, 8'd3, 16'd0, 16'd0, 16'd0);
        send_word(CMD_NOP, 17'h1FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(CMD_INIT, 17'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        write_reg(REG_WORDS, 17'd70);
        send_word(CMD_INIT, 17'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        // Fill the table with one-word grants until it is full
        for (int n = 0; n < 70; n++)
            send_word(CMD_ALLOC, 17'd1, 8'(n + 1), 16'd0, 16'd0, 16'd0);
        write_reg(REG_WORDS, 17'd0);
        send_word(CMD_INIT, 17'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        send_word(CMD_ALLOC, 17'd1, 8'd5, 16'd0, 16'd0, 16'd0);
        write_reg(REG_WORDS, 17'h1FFFF);
        send_word(CMD_INIT, 17'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        held_start.delete();
        held_end.delete();
        held_owner.delete();

        // Random phases across policies and memory sizes
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin
                idle_send = 54;
                idle_recv = 32;
            end
            if (phase == 8) begin
                idle_send = 0;
                idle_recv = 0;
            end
            words = (phase % 3 == 0) ? 65536 : (phase % 3 == 1) ? 1 + $urandom_range(300) : 256;
            write_reg(REG_POLICY, 17'(phase % 4));
            write_reg(REG_WORDS, 17'(words));
            send_word(CMD_INIT, 17'd0, 8'd0, 16'd0, 16'd0, 16'd0);
            held_start.delete();
            held_end.delete();
            held_owner.delete();
            for (int n = 0; n < 130; n++) begin
                random_word(words);
                // Hold off until the block has gone quiet
                if (n == 60) while (pending_count != 0) @(negedge clk);
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== segment_map_allocator.f =====
+incdir+rtl/core
rtl/core/smap_pkg.sv
rtl/core/smap_table.sv
rtl/core/segment_map_allocator.sv
bench/smap_checker.sv
bench/tb_segment_map_allocator.sv
